>>> rtl/cpu_frequency_step_governor_macros.svh
// ----------------------------------------------------------------------------
// cpu_frequency_step_governor_macros
// Assertion macros shared by the governor RTL.
// ----------------------------------------------------------------------------
`ifndef CPU_FREQUENCY_STEP_GOVERNOR_MACROS_SVH
`define CPU_FREQUENCY_STEP_GOVERNOR_MACROS_SVH

// property holds on every clock outside reset
`define CFSG_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition never true outside reset
`define CFSG_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

>>> rtl/cfsg_pkg.sv
// ----------------------------------------------------------------------------
// cfsg_pkg
// Widths, codes and constants of the frequency step governor.
// ----------------------------------------------------------------------------
package cfsg_pkg;

	localparam int FREQ_W     = 24;
	localparam int PCT_W      = 7;
	localparam int OP_W       = 1;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = FREQ_W;

	// op codes
	localparam logic [OP_W-1:0] OP_SAMPLE = 1'b0;
	localparam logic [OP_W-1:0] OP_START  = 1'b1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BUSY_THR     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HISPEED_PCT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_DROP    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_FREQ     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_FREQ     = 3'd4;

	// register reset values
	localparam logic [PCT_W-1:0]  RST_BUSY_THR     = 7'd70;
	localparam logic [PCT_W-1:0]  RST_HISPEED_PCT  = 7'd80;
	localparam logic [PCT_W-1:0]  RST_IDLE_DROP    = 7'd15;
	localparam logic [FREQ_W-1:0] RST_MAX_FREQ     = 24'hFF_FFFF;
	localparam logic [FREQ_W-1:0] RST_MIN_FREQ     = 24'd0;

	localparam logic [PCT_W-1:0] IDLE_LOAD = 7'd10;

	// percent * max / 100 via reciprocal: exact for products below 2^31
	localparam int PROD_W      = PCT_W + FREQ_W;
	localparam int RECIP_W     = 32;
	localparam int RECIP_SH    = 38;
	localparam int QUOT_W      = FREQ_W + 1;
	localparam int QFULL_W     = RECIP_SH + QUOT_W;
	localparam logic [RECIP_W-1:0] RECIP_100 = 32'd2748779070;

	// count that holds items off after a register write while derived points settle
	localparam logic [1:0] UPD_LAT = 2'd2;

endpackage

>>> rtl/cfsg_ifs.sv
// ----------------------------------------------------------------------------
// cfsg_ifs
// Valid/ready channels of the governor: sample items in, requests out.
// ----------------------------------------------------------------------------
interface cfsg_in_if;
	logic                          valid;
	logic                          ready;
	logic [cfsg_pkg::OP_W-1:0]     op;
	logic [cfsg_pkg::PCT_W-1:0]    load_percent;
	logic [cfsg_pkg::FREQ_W-1:0]   current_freq;

	modport source (output valid, output op, output load_percent, output current_freq,
		input ready);
	modport sink (input valid, input op, input load_percent, input current_freq,
		output ready);
endinterface

interface cfsg_out_if;
	logic                          valid;
	logic                          ready;
	logic [cfsg_pkg::FREQ_W-1:0]   request_freq;
	logic                          round_down;

	modport source (output valid, output request_freq, output round_down, input ready);
	modport sink (input valid, input request_freq, input round_down, output ready);
endinterface

>>> rtl/cpu_frequency_step_governor.sv
// ----------------------------------------------------------------------------
// cpu_frequency_step_governor
// Per-sample frequency step governor with a kept target frequency.
// ----------------------------------------------------------------------------
// Usage:
//   item   : valid/ready channel of samples. op start loads the kept target
//            from current_freq and gives no request; op sample evaluates
//            load_percent and may give one request.
//   result : valid/ready channel of requests (request_freq, round_down).
//   cfg_*  : write port for the busy threshold, hispeed_percent,
//            idle_drop_percent, max_freq, min_freq; write only while idle.
// Path: item register, then result register for any request.
// Throughput: one item per cycle while no held request or register write
//   blocks item.ready; the kept target is one register updated by a single
//   compare/subtract step between the item register and the result register.
// Reset and writes: upd_cnt_q holds item.ready low after reset release and
//   after each register write while the high-speed point and idle drop
//   (percent * max / 100, multiply by reciprocal) settle in a 3-stage chain.
// Stall: a held request stays in the result register; the item register
//   still takes one more item; one with a request waits for the result slot.
// ----------------------------------------------------------------------------
`include "cpu_frequency_step_governor_macros.svh"

module cpu_frequency_step_governor (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [cfsg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [cfsg_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	cfsg_in_if.sink                           item,
	cfsg_out_if.source                        result
);
	import cfsg_pkg::*;

	logic [PCT_W-1:0]   up_thr_q;
	logic [PCT_W-1:0]   hs_pct_q;
	logic [PCT_W-1:0]   drop_pct_q;
	logic [FREQ_W-1:0]  max_freq_q;
	logic [FREQ_W-1:0]  min_freq_q;
	logic [1:0]         upd_cnt_q;

	logic [PROD_W-1:0]  prod_hs_s1;
	logic [PROD_W-1:0]  prod_drop_s1;
	logic [QFULL_W-1:0] qfull_hs;
	logic [QFULL_W-1:0] qfull_drop;
	logic [QUOT_W-1:0]  quot_hs_s2;
	logic [QUOT_W-1:0]  drop_s2;
	logic [FREQ_W-1:0]  hispeed_s3;

	logic               s1_valid_q;
	logic [OP_W-1:0]    op_s1;
	logic [PCT_W-1:0]   load_s1;
	logic [FREQ_W-1:0]  cur_s1;

	logic [FREQ_W-1:0]  target_q;
	logic [FREQ_W-1:0]  next_target;
	logic [FREQ_W-1:0]  decayed;
	logic [FREQ_W-1:0]  floored;
	logic               has_res;
	logic               res_round_down;
	logic               s1_retire;
	logic               item_acc;

	logic               res_valid_q;
	logic [FREQ_W-1:0]  res_freq_q;
	logic               res_rd_q;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_thr_q   <= RST_BUSY_THR;
			hs_pct_q   <= RST_HISPEED_PCT;
			drop_pct_q <= RST_IDLE_DROP;
			max_freq_q <= RST_MAX_FREQ;
			min_freq_q <= RST_MIN_FREQ;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BUSY_THR:     up_thr_q   <= cfg_wdata[PCT_W-1:0];
				REG_HISPEED_PCT:  hs_pct_q   <= cfg_wdata[PCT_W-1:0];
				REG_IDLE_DROP:    drop_pct_q <= cfg_wdata[PCT_W-1:0];
				REG_MAX_FREQ:     max_freq_q <= cfg_wdata[FREQ_W-1:0];
				REG_MIN_FREQ:     min_freq_q <= cfg_wdata[FREQ_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upd_cnt_q <= UPD_LAT;
		end else if (cfg_we) begin
			upd_cnt_q <= UPD_LAT;
		end else if (upd_cnt_q != 2'd0) begin
			upd_cnt_q <= upd_cnt_q - 2'd1;
		end
	end

	// derived points, free running
	assign qfull_hs   = QFULL_W'(prod_hs_s1) * QFULL_W'(RECIP_100);
	assign qfull_drop = QFULL_W'(prod_drop_s1) * QFULL_W'(RECIP_100);

	always_ff @(posedge clk) begin
		prod_hs_s1   <= PROD_W'(hs_pct_q) * PROD_W'(max_freq_q);
		prod_drop_s1 <= PROD_W'(drop_pct_q) * PROD_W'(max_freq_q);
		quot_hs_s2   <= qfull_hs[RECIP_SH +: QUOT_W];
		drop_s2      <= qfull_drop[RECIP_SH +: QUOT_W];
		hispeed_s3   <= (quot_hs_s2 > {1'b0, max_freq_q}) ? max_freq_q
			: quot_hs_s2[FREQ_W-1:0];
	end

	// item register
	assign item_acc   = item.valid && item.ready;
	assign s1_retire  = s1_valid_q && (!has_res || !res_valid_q || result.ready);
	assign item.ready = (!s1_valid_q || s1_retire) && (upd_cnt_q == 2'd0) && !cfg_we;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (item_acc) begin
			s1_valid_q <= 1'b1;
		end else if (s1_retire) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc) begin
			op_s1   <= item.op;
			load_s1 <= item.load_percent;
			cur_s1  <= item.current_freq;
		end
	end

	// step
	assign decayed = ({1'b0, target_q} > drop_s2) ? (target_q - drop_s2[FREQ_W-1:0])
		: '0;
	assign floored = (decayed < min_freq_q) ? min_freq_q : decayed;

	always_comb begin
		next_target    = target_q;
		has_res        = 1'b0;
		res_round_down = 1'b0;
		priority if (op_s1 == OP_START) begin
			next_target = cur_s1;
		end else if (load_s1 > up_thr_q) begin
			has_res        = 1'b1;
			res_round_down = 1'b1;
			next_target    = (target_q >= hispeed_s3) ? max_freq_q : hispeed_s3;
		end else if (load_s1 < IDLE_LOAD) begin
			has_res     = 1'b1;
			next_target = floored;
		end else if ((load_s1 < up_thr_q) && (target_q > hispeed_s3)) begin
			has_res     = 1'b1;
			next_target = hispeed_s3;
		end else begin
			has_res = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
		end else if (s1_retire) begin
			target_q <= next_target;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_retire && has_res) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_retire && has_res) begin
			res_freq_q <= next_target;
			res_rd_q   <= res_round_down;
		end
	end

	assign result.valid        = res_valid_q;
	assign result.request_freq = res_freq_q;
	assign result.round_down   = res_rd_q;

	`CFSG_ASSERT(a_start_loads_target, (s1_retire && op_s1 == OP_START) |=> (target_q == $past(cur_s1)), "start item did not load target")
	`CFSG_ASSERT(a_request_is_target, (s1_retire && has_res) |=> (res_valid_q && res_freq_q == target_q), "request differs from kept target")
	`CFSG_ASSERT_NEVER(a_no_overwrite, res_valid_q && !result.ready && s1_retire && has_res, "held request overwritten")
	`CFSG_ASSERT(a_write_blocks_items, cfg_we |=> !item.ready, "item taken before derived points settled")

endmodule
